// File: rtl/gda_pkg.sv
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 21;

  localparam int DN_W    = 25;
  localparam int YC_W    = 15;
  localparam int YF_W    = 16;
  localparam int CNT_W   = 4;
  localparam int DOY_W   = 9;
  localparam int MLEN_W  = 5;
  localparam int YSTEP_W = 9;

  localparam int YEAR_BIAS  = 4000;
  localparam int YEAR_MAX   = 9999;
  localparam int ERA_DAYS   = 146097;
  localparam int CENT_DAYS  = 36524;
  localparam int QUAD_DAYS  = 1461;
  localparam int YEAR_DAYS  = 365;
  localparam int ERA_YEARS  = 400;
  localparam int CENT_YEARS = 100;
  localparam int QUAD_YEARS = 4;
  localparam int ONE_YEAR   = 1;

  localparam int CENT_LAST = 3;
  localparam int YEAR_LAST = 3;
  localparam int MON_LAST  = 11;
  localparam int MP_WRAP   = 10;
  localparam int MP_TO_MAR = 3;
  localparam int MP_TO_JAN = 9;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENC_ERA,
    S_ENC_CENT,
    S_ENC_QUAD,
    S_ENC_YEAR,
    S_OFF,
    S_DEC_ERA,
    S_DEC_CENT,
    S_DEC_QUAD,
    S_DEC_YEAR,
    S_DEC_MON,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DM_INIT,
    DM_ADD,
    DM_SUB,
    DM_OFF
  } dn_mode_t;

  typedef enum logic [1:0] {
    YM_INIT,
    YM_CLR,
    YM_SUB,
    YM_ADD
  } yc_mode_t;

  typedef enum logic [2:0] {
    K_ERA,
    K_CENT,
    K_QUAD,
    K_YEAR,
    K_MON
  } k_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLR,
    CNT_INC
  } cnt_op_t;

  typedef struct packed {
    dn_mode_t dn_mode;
    logic     dn_we;
    yc_mode_t yc_mode;
    logic     yc_we;
    k_sel_t   k_sel;
    cnt_op_t  cnt_op;
    logic     finish;
  } ctl_t;

  typedef struct packed {
    logic               dn_ge;
    logic               yc_ge;
    logic [CNT_W-1:0]   cnt;
    logic [YF_W-1:0]    fin_year;
    logic [MONTH_W-1:0] fin_month;
    logic [DAY_W-1:0]   fin_day;
  } stat_t;

  // day of the march-based year on which month m starts
  function automatic logic [DOY_W-1:0] doy_of_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // month lengths of the march-based year, february last
  function automatic logic [MLEN_W-1:0] month_len(input logic [CNT_W-1:0] mp);
    logic [MLEN_W-1:0] r;
    case (mp)
      4'd1, 4'd3, 4'd6, 4'd8: r = 5'd30;
      4'd11:                  r = 5'd29;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/gda_ctrl.sv
module gda_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  gda_pkg::stat_t  stat,
  output gda_pkg::ctl_t   ctl,
  output logic            busy
);

  localparam int CW = gda_pkg::CNT_W;

  gda_pkg::state_t state, state_next;
  logic cent_room, year_room, mon_room;

  assign cent_room = stat.cnt < CW'(gda_pkg::CENT_LAST);
  assign year_room = stat.cnt < CW'(gda_pkg::YEAR_LAST);
  assign mon_room  = stat.cnt < CW'(gda_pkg::MON_LAST);
  assign busy      = state != gda_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gda_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gda_pkg::S_IDLE:     if (start) state_next = gda_pkg::S_ENC_ERA;
      gda_pkg::S_ENC_ERA:  if (!stat.yc_ge) state_next = gda_pkg::S_ENC_CENT;
      gda_pkg::S_ENC_CENT: if (!stat.yc_ge) state_next = gda_pkg::S_ENC_QUAD;
      gda_pkg::S_ENC_QUAD: if (!stat.yc_ge) state_next = gda_pkg::S_ENC_YEAR;
      gda_pkg::S_ENC_YEAR: if (!stat.yc_ge) state_next = gda_pkg::S_OFF;
      gda_pkg::S_OFF:      state_next = gda_pkg::S_DEC_ERA;
      gda_pkg::S_DEC_ERA:  if (!stat.dn_ge) state_next = gda_pkg::S_DEC_CENT;
      gda_pkg::S_DEC_CENT: if (!(stat.dn_ge && cent_room)) state_next = gda_pkg::S_DEC_QUAD;
      gda_pkg::S_DEC_QUAD: if (!stat.dn_ge) state_next = gda_pkg::S_DEC_YEAR;
      gda_pkg::S_DEC_YEAR: if (!(stat.dn_ge && year_room)) state_next = gda_pkg::S_DEC_MON;
      gda_pkg::S_DEC_MON:  if (!(stat.dn_ge && mon_room)) state_next = gda_pkg::S_DONE;
      gda_pkg::S_DONE:     state_next = gda_pkg::S_IDLE;
      default:             state_next = gda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.dn_mode = gda_pkg::DM_ADD;
    ctl.dn_we   = 1'b0;
    ctl.yc_mode = gda_pkg::YM_SUB;
    ctl.yc_we   = 1'b0;
    ctl.k_sel   = gda_pkg::K_ERA;
    ctl.cnt_op  = gda_pkg::CNT_HOLD;
    ctl.finish  = 1'b0;
    unique case (state)
      gda_pkg::S_IDLE: begin
        ctl.dn_mode = gda_pkg::DM_INIT;
        ctl.dn_we   = start;
        ctl.yc_mode = gda_pkg::YM_INIT;
        ctl.yc_we   = start;
        ctl.cnt_op  = gda_pkg::CNT_CLR;
      end
      gda_pkg::S_ENC_ERA, gda_pkg::S_ENC_CENT, gda_pkg::S_ENC_QUAD,
      gda_pkg::S_ENC_YEAR: begin
        ctl.dn_mode = gda_pkg::DM_ADD;
        ctl.dn_we   = stat.yc_ge;
        ctl.yc_mode = gda_pkg::YM_SUB;
        ctl.yc_we   = stat.yc_ge;
        case (state)
          gda_pkg::S_ENC_CENT: ctl.k_sel = gda_pkg::K_CENT;
          gda_pkg::S_ENC_QUAD: ctl.k_sel = gda_pkg::K_QUAD;
          gda_pkg::S_ENC_YEAR: ctl.k_sel = gda_pkg::K_YEAR;
          default:             ctl.k_sel = gda_pkg::K_ERA;
        endcase
      end
      gda_pkg::S_OFF: begin
        ctl.dn_mode = gda_pkg::DM_OFF;
        ctl.dn_we   = 1'b1;
        ctl.yc_mode = gda_pkg::YM_CLR;
        ctl.yc_we   = 1'b1;
        ctl.cnt_op  = gda_pkg::CNT_CLR;
      end
      gda_pkg::S_DEC_ERA, gda_pkg::S_DEC_QUAD: begin
        ctl.k_sel   = (state == gda_pkg::S_DEC_ERA) ? gda_pkg::K_ERA : gda_pkg::K_QUAD;
        ctl.dn_mode = gda_pkg::DM_SUB;
        ctl.dn_we   = stat.dn_ge;
        ctl.yc_mode = gda_pkg::YM_ADD;
        ctl.yc_we   = stat.dn_ge;
        ctl.cnt_op  = stat.dn_ge ? gda_pkg::CNT_HOLD : gda_pkg::CNT_CLR;
      end
      gda_pkg::S_DEC_CENT, gda_pkg::S_DEC_YEAR: begin
        ctl.k_sel   = (state == gda_pkg::S_DEC_CENT) ? gda_pkg::K_CENT : gda_pkg::K_YEAR;
        ctl.dn_mode = gda_pkg::DM_SUB;
        ctl.yc_mode = gda_pkg::YM_ADD;
        if (stat.dn_ge && ((state == gda_pkg::S_DEC_CENT) ? cent_room : year_room)) begin
          ctl.dn_we  = 1'b1;
          ctl.yc_we  = 1'b1;
          ctl.cnt_op = gda_pkg::CNT_INC;
        end else begin
          ctl.cnt_op = gda_pkg::CNT_CLR;
        end
      end
      gda_pkg::S_DEC_MON: begin
        ctl.k_sel   = gda_pkg::K_MON;
        ctl.dn_mode = gda_pkg::DM_SUB;
        ctl.dn_we   = stat.dn_ge && mon_room;
        ctl.cnt_op  = (stat.dn_ge && mon_room) ? gda_pkg::CNT_INC : gda_pkg::CNT_HOLD;
      end
      gda_pkg::S_DONE: begin
        ctl.finish = 1'b1;
      end
      default: begin
        ctl.finish = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/gda_dp.sv
module gda_dp (
  input  logic                            clk,
  input  gda_pkg::ctl_t                   ctl,
  input  logic [gda_pkg::YEAR_W-1:0]      start_year,
  input  logic [gda_pkg::MONTH_W-1:0]     start_month,
  input  logic [gda_pkg::DAY_W-1:0]       start_day,
  input  logic signed [gda_pkg::OFF_W-1:0] offset,
  output gda_pkg::stat_t                  stat
);

  localparam int DW  = gda_pkg::DN_W;
  localparam int YW  = gda_pkg::YC_W;
  localparam int FW  = gda_pkg::YF_W;
  localparam int CW  = gda_pkg::CNT_W;
  localparam int MW  = gda_pkg::MONTH_W;
  localparam int DYW = gda_pkg::DAY_W;
  localparam int OW  = gda_pkg::OFF_W;

  logic [DW-1:0] dn;
  logic [YW-1:0] yc;
  logic [CW-1:0] cnt;

  logic [DW-1:0] k_days, dn_a, dn_b;
  logic          dn_cin;
  logic [DW:0]   dn_sum;
  logic [YW-1:0] k_years, yc_a, yc_b;
  logic          yc_cin;
  logic [YW:0]   yc_sum;
  logic          early_month;
  logic [MW-1:0] mm;

  assign early_month = (start_month == gda_pkg::MONTH_JAN) ||
                       (start_month == gda_pkg::MONTH_FEB);

  always_comb begin
    case (ctl.k_sel)
      gda_pkg::K_ERA: begin
        k_days  = DW'(gda_pkg::ERA_DAYS);
        k_years = YW'(gda_pkg::ERA_YEARS);
      end
      gda_pkg::K_CENT: begin
        k_days  = DW'(gda_pkg::CENT_DAYS);
        k_years = YW'(gda_pkg::CENT_YEARS);
      end
      gda_pkg::K_QUAD: begin
        k_days  = DW'(gda_pkg::QUAD_DAYS);
        k_years = YW'(gda_pkg::QUAD_YEARS);
      end
      gda_pkg::K_YEAR: begin
        k_days  = DW'(gda_pkg::YEAR_DAYS);
        k_years = YW'(gda_pkg::ONE_YEAR);
      end
      default: begin
        k_days  = DW'(gda_pkg::month_len(cnt));
        k_years = '0;
      end
    endcase
  end

  // shared day adder: load, step up, step down with borrow as compare, add offset
  always_comb begin
    dn_a   = dn;
    dn_b   = k_days;
    dn_cin = 1'b0;
    case (ctl.dn_mode)
      gda_pkg::DM_INIT: begin
        dn_a = DW'(gda_pkg::doy_of_month(start_month)) + DW'(start_day);
        dn_b = '1;
      end
      gda_pkg::DM_SUB: begin
        dn_b   = ~k_days;
        dn_cin = 1'b1;
      end
      gda_pkg::DM_OFF: begin
        dn_b = {{(DW-OW){offset[OW-1]}}, offset};
      end
      default: begin
        dn_b = k_days;
      end
    endcase
    dn_sum = {1'b0, dn_a} + {1'b0, dn_b} + (DW+1)'(dn_cin);
  end

  always_comb begin
    yc_a   = yc;
    yc_b   = k_years;
    yc_cin = 1'b0;
    case (ctl.yc_mode)
      gda_pkg::YM_INIT: begin
        yc_a = YW'(start_year);
        yc_b = YW'(gda_pkg::YEAR_BIAS) - YW'(early_month);
      end
      gda_pkg::YM_CLR: begin
        yc_a = '0;
        yc_b = '0;
      end
      gda_pkg::YM_SUB: begin
        yc_b   = ~k_years;
        yc_cin = 1'b1;
      end
      default: begin
        yc_b = k_years;
      end
    endcase
    yc_sum = {1'b0, yc_a} + {1'b0, yc_b} + (YW+1)'(yc_cin);
  end

  always_ff @(posedge clk) begin
    if (ctl.dn_we) begin
      dn <= dn_sum[DW-1:0];
    end
    if (ctl.yc_we) begin
      yc <= yc_sum[YW-1:0];
    end
    case (ctl.cnt_op)
      gda_pkg::CNT_CLR: cnt <= '0;
      gda_pkg::CNT_INC: cnt <= cnt + CW'(1);
      default:          cnt <= cnt;
    endcase
  end

  assign mm = (cnt < CW'(gda_pkg::MP_WRAP)) ? MW'(cnt + CW'(gda_pkg::MP_TO_MAR))
                                            : MW'(cnt - CW'(gda_pkg::MP_TO_JAN));

  assign stat.dn_ge     = dn_sum[DW];
  assign stat.yc_ge     = yc_sum[YW];
  assign stat.cnt       = cnt;
  assign stat.fin_month = mm;
  assign stat.fin_day   = dn[DYW-1:0] + DYW'(1);
  assign stat.fin_year  = FW'(yc) + FW'(mm <= gda_pkg::MONTH_FEB) - FW'(gda_pkg::YEAR_BIAS);

endmodule

// File: rtl/gregorian_date_add_days.sv
// Adds a signed day offset to a proleptic Gregorian date.
//
// Request channel: drive start_year, start_month, start_day and offset_days with
// start high; the request is taken at a rising edge where start is high and busy
// is low. busy stays high while the request is worked on.
// Result channel: done is high for exactly one cycle with result_year,
// result_month, result_day and range_error valid in that cycle. The receiver
// cannot hold results off and must take them when done is high.
// The date is turned into a day count and back by a shared day adder and a
// year adder that step 400-year eras, centuries, four-year groups, years and
// months, one step per cycle; stepping eras dominates. A new request is taken
// in the cycle done is high.
// range_error is set for a month outside 1..12 or a result year outside
// 0..9999, and the date fields then echo the request.
// Reset (rst, synchronous) returns the sequencer to idle and drops done; a
// request in flight is lost.
module gregorian_date_add_days (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [gda_pkg::YEAR_W-1:0]        start_year,
  input  logic [gda_pkg::MONTH_W-1:0]       start_month,
  input  logic [gda_pkg::DAY_W-1:0]         start_day,
  input  logic signed [gda_pkg::OFF_W-1:0]  offset_days,
  output logic                              done,
  output logic [gda_pkg::YEAR_W-1:0]        result_year,
  output logic [gda_pkg::MONTH_W-1:0]       result_month,
  output logic [gda_pkg::DAY_W-1:0]         result_day,
  output logic                              range_error
);

  localparam int FW = gda_pkg::YF_W;
  localparam int YW = gda_pkg::YEAR_W;

  gda_pkg::ctl_t  ctl;
  gda_pkg::stat_t stat;

  logic [gda_pkg::YEAR_W-1:0]       sy_q;
  logic [gda_pkg::MONTH_W-1:0]      sm_q;
  logic [gda_pkg::DAY_W-1:0]        sd_q;
  logic signed [gda_pkg::OFF_W-1:0] off_q;
  logic accept, bad_month, fy_neg, fy_big, bad;

  assign accept = start && !busy;

  gda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  gda_dp u_dp (
    .clk         (clk),
    .ctl         (ctl),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .offset      (off_q),
    .stat        (stat)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      sy_q  <= start_year;
      sm_q  <= start_month;
      sd_q  <= start_day;
      off_q <= offset_days;
    end
  end

  assign bad_month = (sm_q < gda_pkg::MONTH_JAN) || (sm_q > gda_pkg::MONTH_DEC);
  assign fy_neg    = stat.fin_year[FW-1];
  assign fy_big    = !fy_neg && (stat.fin_year > FW'(gda_pkg::YEAR_MAX));
  assign bad       = bad_month || fy_neg || fy_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      range_error  <= bad;
      result_year  <= bad ? sy_q : stat.fin_year[YW-1:0];
      result_month <= bad ? sm_q : stat.fin_month;
      result_day   <= bad ? sd_q : stat.fin_day;
    end
  end

  a_done_follows_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.finish))
    else $error("result strobe without a finished request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted but sequencer not busy");

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is in flight");

  a_month_valid: assert property (@(posedge clk) disable iff (rst)
    (done && !range_error) |->
      (result_month >= gda_pkg::MONTH_JAN && result_month <= gda_pkg::MONTH_DEC))
    else $error("in-range result with an invalid month");

endmodule
